// ===== src/rrts_pkg.sv =====
`default_nettype none

package rrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int COUNT_W = $clog2(NUM_SLOTS + 1);
  localparam int FUNC_W = 3;
  localparam int ID_W = 32;
  localparam int TIME_W = 32;
  localparam int SLICE_W = 32;
  localparam int TS_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_YIELD  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SLEEP  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_EXIT   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 1'd1;

  localparam logic [TS_W-1:0] SLICE_LEN_RESET = 16'd10;
  localparam logic [TIME_W-1:0] WARMUP_RESET = 32'd100;

  typedef enum logic [1:0] {
    ST_TERMINATED = 2'd0,
    ST_READY      = 2'd1,
    ST_RUNNING    = 2'd2,
    ST_SLEEPING   = 2'd3
  } slot_status_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] sleep_ticks;
  } item_t;

  typedef struct packed {
    logic              running_valid;
    logic [SLOT_W-1:0] running_slot;
    logic [ID_W-1:0]   running_id;
    logic [ID_W-1:0]   created_id;
    logic              switched;
    logic [COUNT_W-1:0] ready_count;
    logic [TIME_W-1:0] tick_count;
  } result_t;

  // Controller to datapath: one step per cycle
  typedef struct packed {
    logic accept;
    logic time_inc;
    logic wake_step;
    logic create_step;
    logic slice_step;
    logic sleep_cur;
    logic exit_cur;
    logic pop;
    logic run;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_idx;
    logic free_hit;
    logic cur_valid;
    logic slice_zero;
    logic fifo_empty;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/rrts_ctrl.sv =====
`default_nettype none

module rrts_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [rrts_pkg::FUNC_W-1:0]     func,
  input  wire rrts_pkg::stat_t                 stat,
  output rrts_pkg::cmd_t                       cmd,
  output logic                                 busy,
  output logic                                 done
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_T_INC  = 10'b0000000010,
    S_T_SCAN = 10'b0000000100,
    S_T_SLC  = 10'b0000001000,
    S_C_SCAN = 10'b0000010000,
    S_SLEEP  = 10'b0000100000,
    S_EXIT   = 10'b0001000000,
    S_POP    = 10'b0010000000,
    S_RUN    = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (func)
            rrts_pkg::FUNC_TICK:   state_next = S_T_INC;
            rrts_pkg::FUNC_CREATE: state_next = S_C_SCAN;
            rrts_pkg::FUNC_YIELD:  state_next = S_POP;
            rrts_pkg::FUNC_SLEEP:  state_next = S_SLEEP;
            rrts_pkg::FUNC_EXIT:   state_next = S_EXIT;
            default:               state_next = S_FIN;
          endcase
        end
      end
      S_T_INC: begin
        cmd.time_inc = 1'b1;
        state_next = S_T_SCAN;
      end
      S_T_SCAN: begin
        cmd.wake_step = 1'b1;
        if (stat.last_idx) state_next = S_T_SLC;
      end
      S_T_SLC: begin
        cmd.slice_step = 1'b1;
        state_next = stat.slice_zero ? S_POP : S_FIN;
      end
      S_C_SCAN: begin
        cmd.create_step = 1'b1;
        if (stat.free_hit || stat.last_idx) state_next = S_FIN;
      end
      S_SLEEP: begin
        cmd.sleep_cur = 1'b1;
        state_next = stat.cur_valid ? S_POP : S_FIN;
      end
      S_EXIT: begin
        cmd.exit_cur = 1'b1;
        state_next = stat.cur_valid ? S_POP : S_FIN;
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_next = stat.fifo_empty ? S_FIN : S_RUN;
      end
      S_RUN: begin
        cmd.run = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_FIN);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== src/rrts_dp.sv =====
`default_nettype none

module rrts_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rrts_pkg::item_t                   item,
  input  wire rrts_pkg::cmd_t                    cmd,
  input  wire logic                              cfg_we,
  input  wire logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrts_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rrts_pkg::stat_t                        stat,
  output rrts_pkg::result_t                      result
);

  localparam int SW = rrts_pkg::SLOT_W;
  localparam int CW = rrts_pkg::COUNT_W;
  localparam int N = rrts_pkg::NUM_SLOTS;

  function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
    ptr_inc = (p == rrts_pkg::LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // Slot table and ready queue
  rrts_pkg::slot_status_t            slot_status [N];
  logic [rrts_pkg::ID_W-1:0]         slot_task_id [N];
  logic [rrts_pkg::SLICE_W-1:0]      slot_slice_left [N];
  logic [rrts_pkg::TIME_W-1:0]       slot_wake_time [N];
  logic [SW-1:0]                     ready_fifo [N];

  logic [SW-1:0]                     fifo_head;
  logic [SW-1:0]                     fifo_tail;
  logic [CW-1:0]                     fifo_count;
  logic [SW-1:0]                     cur_slot;
  logic                              cur_valid;
  logic [rrts_pkg::TIME_W-1:0]       sys_time;
  logic [rrts_pkg::ID_W-1:0]         next_id;
  logic [SW-1:0]                     idx;
  logic [SW-1:0]                     nxt_slot;
  logic [rrts_pkg::TS_W-1:0]         slice_len;
  logic [rrts_pkg::TIME_W-1:0]       warmup;
  logic [rrts_pkg::TIME_W-1:0]       sleep_ticks;
  logic [rrts_pkg::ID_W-1:0]         created;
  logic                              sw;

  logic [SW-1:0]                     rd_addr;
  rrts_pkg::slot_status_t            rd_status;
  logic                              wake_hit;
  logic                              free_hit;
  logic                              dec_en;
  logic [rrts_pkg::SLICE_W-1:0]      slice_dec;
  logic                              pop_ok;
  logic                              requeue;
  logic                              push_en;
  logic                              push_ok;
  logic [SW-1:0]                     push_slot;
  logic [rrts_pkg::SLICE_W-1:0]      slice_full;

  logic                              st_we;
  logic [SW-1:0]                     st_waddr;
  rrts_pkg::slot_status_t            st_wdata;
  logic                              sl_we;
  logic [SW-1:0]                     sl_waddr;
  logic [rrts_pkg::SLICE_W-1:0]      sl_wdata;
  logic                              wk_we;
  logic [SW-1:0]                     wk_waddr;
  logic [rrts_pkg::TIME_W-1:0]       wk_wdata;
  logic                              create_ok;

  // One status read a cycle: scan index during scans, else the current slot
  assign rd_addr   = (cmd.wake_step || cmd.create_step) ? idx : cur_slot;
  assign rd_status = slot_status[rd_addr];

  assign wake_hit  = (rd_status == rrts_pkg::ST_SLEEPING) && (slot_wake_time[idx] <= sys_time);
  assign free_hit  = (rd_status == rrts_pkg::ST_TERMINATED);
  assign create_ok = cmd.create_step && free_hit;

  assign dec_en    = cur_valid && (sys_time > warmup);
  assign slice_dec = slot_slice_left[cur_slot] - 1'b1;
  assign slice_full = rrts_pkg::SLICE_W'(slice_len);

  assign pop_ok  = cmd.pop && (fifo_count != '0);
  assign requeue = pop_ok && cur_valid && (rd_status == rrts_pkg::ST_RUNNING);

  always_comb begin
    push_en   = 1'b0;
    push_slot = idx;
    st_we     = 1'b0;
    st_waddr  = cur_slot;
    st_wdata  = rrts_pkg::ST_READY;
    sl_we     = 1'b0;
    sl_waddr  = cur_slot;
    sl_wdata  = slice_full;
    wk_we     = 1'b0;
    wk_waddr  = cur_slot;
    wk_wdata  = '0;
    if (cmd.wake_step && wake_hit) begin
      push_en  = 1'b1;
      st_we    = 1'b1;
      st_waddr = idx;
    end else if (create_ok) begin
      push_en  = 1'b1;
      st_we    = 1'b1;
      st_waddr = idx;
      sl_we    = 1'b1;
      sl_waddr = idx;
      wk_we    = 1'b1;
      wk_waddr = idx;
    end else if (cmd.slice_step && dec_en) begin
      sl_we    = 1'b1;
      sl_wdata = slice_dec;
    end else if (cmd.sleep_cur && cur_valid) begin
      st_we    = 1'b1;
      st_wdata = rrts_pkg::ST_SLEEPING;
      wk_we    = 1'b1;
      wk_wdata = sys_time + sleep_ticks;
    end else if (cmd.exit_cur && cur_valid) begin
      st_we    = 1'b1;
      st_wdata = rrts_pkg::ST_TERMINATED;
    end else if (requeue) begin
      push_en   = 1'b1;
      push_slot = cur_slot;
      st_we     = 1'b1;
      sl_we     = 1'b1;
    end else if (cmd.run) begin
      st_we    = 1'b1;
      st_waddr = nxt_slot;
      st_wdata = rrts_pkg::ST_RUNNING;
      sl_we    = 1'b1;
      sl_waddr = nxt_slot;
    end
  end

  // Drop the push when the queue is full; a pop in the same cycle makes room
  assign push_ok = push_en && ((fifo_count < rrts_pkg::MAX_COUNT) || pop_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        slot_status[i] <= rrts_pkg::ST_TERMINATED;
      end
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
      cur_slot   <= '0;
      cur_valid  <= 1'b0;
      sys_time   <= '0;
      next_id    <= rrts_pkg::ID_W'(1);
      idx        <= '0;
      slice_len  <= rrts_pkg::SLICE_LEN_RESET;
      warmup     <= rrts_pkg::WARMUP_RESET;
    end else begin
      if (cfg_we && (cfg_index == rrts_pkg::REG_SLICE_LEN)) begin
        slice_len <= cfg_data[rrts_pkg::TS_W-1:0];
      end
      if (cfg_we && (cfg_index == rrts_pkg::REG_WARMUP)) begin
        warmup <= cfg_data[rrts_pkg::TIME_W-1:0];
      end
      if (st_we) begin
        slot_status[st_waddr] <= st_wdata;
      end
      if (cmd.accept) begin
        idx <= '0;
      end else if (cmd.wake_step || cmd.create_step) begin
        idx <= ptr_inc(idx);
      end
      if (cmd.time_inc) begin
        sys_time <= sys_time + 1'b1;
      end
      if (create_ok) begin
        next_id <= next_id + 1'b1;
      end
      if (cmd.exit_cur) begin
        cur_valid <= 1'b0;
      end else if (cmd.run) begin
        cur_valid <= 1'b1;
        cur_slot  <= nxt_slot;
      end
      if (pop_ok) begin
        fifo_head <= ptr_inc(fifo_head);
      end
      if (push_ok) begin
        fifo_tail <= ptr_inc(fifo_tail);
      end
      if (push_ok && !pop_ok) begin
        fifo_count <= fifo_count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        fifo_count <= fifo_count - 1'b1;
      end
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (sl_we) begin
      slot_slice_left[sl_waddr] <= sl_wdata;
    end
    if (wk_we) begin
      slot_wake_time[wk_waddr] <= wk_wdata;
    end
    if (create_ok) begin
      slot_task_id[idx] <= next_id;
    end
    if (push_ok) begin
      ready_fifo[fifo_tail] <= push_slot;
    end
    if (pop_ok) begin
      nxt_slot <= ready_fifo[fifo_head];
    end
    if (cmd.accept) begin
      sleep_ticks <= item.sleep_ticks;
      created     <= '0;
      sw          <= 1'b0;
    end else begin
      if (create_ok) begin
        created <= next_id;
      end
      if (cmd.run) begin
        sw <= 1'b1;
      end
    end
    if (cmd.finish) begin
      result.running_valid <= cur_valid;
      result.running_slot  <= cur_valid ? cur_slot : '0;
      result.running_id    <= cur_valid ? slot_task_id[cur_slot] : '0;
      result.created_id    <= created;
      result.switched      <= sw;
      result.ready_count   <= fifo_count;
      result.tick_count    <= sys_time;
    end
  end

  always_comb begin
    stat.last_idx   = (idx == rrts_pkg::LAST_SLOT);
    stat.free_hit   = free_hit;
    stat.cur_valid  = cur_valid;
    stat.slice_zero = dec_en && (slice_dec == '0);
    stat.fifo_empty = (fifo_count == '0);
  end

endmodule

`default_nettype wire

// ===== src/round_robin_task_scheduler.sv =====
// From accept to the done strobe, a tick runs the wake-up scan over the slot table (one
// slot per cycle), then the slice step; create runs the free slot search; yield, sleep
// and exit dispatch the next ready task; an unknown request goes straight to finish.
// One item at a time: a new item is accepted in the cycle done is high. The receiver
// cannot stall results.
// Synchronous active-high reset: all slots terminated, queue empty, no current task.
`default_nettype none

module round_robin_task_scheduler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire rrts_pkg::item_t                   item,
  output logic                                   busy,
  output logic                                   done,
  output rrts_pkg::result_t                      result,
  input  wire logic                              cfg_we,
  input  wire logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrts_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Command and status between the sequencer and the slot/queue datapath
  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  // Sequencer: decodes the request on accept, then steps the datapath one
  // operation per cycle (tick, scan slot, decrement slice, sleep, exit, pop, run, finish).
  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (item.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: slot table, ready queue, tick counter, config registers and
  // the result register, captured on the finish step.
  rrts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

`ifndef SYNTHESIS
  // An accepted item always takes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // A result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without work in progress");

  // Queue occupancy never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.ready_count <= rrts_pkg::MAX_COUNT))
    else $error("ready queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_round_robin_task_scheduler.sv =====
module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  start;
  item_t                 item;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  round_robin_task_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 time unit clock, first rising edge at 5.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: slot table, ready ring and counters, updated once per
  // accepted item, in the order the block accepts them.
  // ---------------------------------------------------------------------------
  slot_status_t      slot_st    [NUM_SLOTS];
  logic [ID_W-1:0]   slot_id    [NUM_SLOTS];
  logic [SLICE_W-1:0] slot_slice [NUM_SLOTS];
  logic [TIME_W-1:0] slot_wake  [NUM_SLOTS];
  logic [SLOT_W-1:0] ring_mem   [NUM_SLOTS];
  int                ring_head;
  int                ring_tail;
  int                ring_count;
  logic [SLOT_W-1:0] cur_slot;
  logic              cur_valid;
  logic [TIME_W-1:0] now_ticks;
  logic [ID_W-1:0]   next_id;

  // Shadow copies of the two configuration registers.
  logic [TS_W-1:0]   cfg_slice;
  logic [TIME_W-1:0] cfg_warmup;

  // Results still owed by the block, oldest first.
  result_t           expected_results [$];
  result_t           oldest;
  int                mismatch_count;

  // When clear, the sender adds no random gap between items.
  logic              idle_enable;

  function automatic void sched_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_st[i]    = ST_TERMINATED;
      slot_id[i]    = '0;
      slot_slice[i] = '0;
      slot_wake[i]  = '0;
      ring_mem[i]   = '0;
    end
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
    cur_slot   = '0;
    cur_valid  = 1'b0;
    now_ticks  = '0;
    next_id    = ID_W'(1);
    cfg_slice  = SLICE_LEN_RESET;
    cfg_warmup = WARMUP_RESET;
  endfunction

  // Append a slot to the ready ring; drop it when the ring is full.
  function automatic void ring_push(input logic [SLOT_W-1:0] s);
    if (ring_count < NUM_SLOTS) begin
      ring_mem[ring_tail] = s;
      ring_tail  = (ring_tail + 1) % NUM_SLOTS;
      ring_count = ring_count + 1;
    end
  endfunction

  // Pop the ring head and make it current. A still-running current task goes
  // back to the tail with a fresh slice. Empty ring: change nothing.
  function automatic logic dispatch_next();
    logic [SLOT_W-1:0] nxt;
    if (ring_count == 0) return 1'b0;
    nxt        = ring_mem[ring_head];
    ring_head  = (ring_head + 1) % NUM_SLOTS;
    ring_count = ring_count - 1;
    if (cur_valid && slot_st[cur_slot] == ST_RUNNING) begin
      slot_st[cur_slot]    = ST_READY;
      slot_slice[cur_slot] = SLICE_W'(cfg_slice);
      ring_push(cur_slot);
    end
    slot_st[nxt]    = ST_RUNNING;
    slot_slice[nxt] = SLICE_W'(cfg_slice);
    cur_slot        = nxt;
    cur_valid       = 1'b1;
    return 1'b1;
  endfunction

  // Apply one request to the shadow and return the result the block owes.
  function automatic result_t sched_step(input item_t it);
    result_t         r;
    logic            sw;
    logic            found;
    logic [ID_W-1:0] created;
    sw      = 1'b0;
    found   = 1'b0;
    created = '0;
    case (it.func)
      FUNC_TICK: begin
        now_ticks = now_ticks + 1'b1;
        // Wake sleepers in index order; wake times compare unsigned.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_st[i] == ST_SLEEPING && slot_wake[i] <= now_ticks) begin
            slot_st[i] = ST_READY;
            ring_push(SLOT_W'(i));
          end
        end
        // Past warm-up, burn one tick of the current slice, whatever the
        // current slot's status; the count wraps below zero.
        if (cur_valid && now_ticks > cfg_warmup) begin
          slot_slice[cur_slot] = slot_slice[cur_slot] - 1'b1;
          if (slot_slice[cur_slot] == '0) sw = dispatch_next();
        end
      end
      FUNC_CREATE: begin
        // Take the first free slot; a full table leaves the id counter alone.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && slot_st[i] == ST_TERMINATED) begin
            found         = 1'b1;
            created       = next_id;
            next_id       = next_id + 1'b1;
            slot_id[i]    = created;
            slot_st[i]    = ST_READY;
            slot_slice[i] = SLICE_W'(cfg_slice);
            slot_wake[i]  = '0;
            ring_push(SLOT_W'(i));
          end
        end
      end
      FUNC_YIELD: sw = dispatch_next();
      FUNC_SLEEP: begin
        if (cur_valid) begin
          slot_st[cur_slot]   = ST_SLEEPING;
          slot_wake[cur_slot] = now_ticks + it.sleep_ticks;
          sw = dispatch_next();
        end
      end
      FUNC_EXIT: begin
        if (cur_valid) begin
          slot_st[cur_slot] = ST_TERMINATED;
          cur_valid         = 1'b0;
          sw = dispatch_next();
        end
      end
      default: ;
    endcase
    r.running_valid = cur_valid;
    r.running_slot  = cur_valid ? cur_slot : '0;
    r.running_id    = cur_valid ? slot_id[cur_slot] : '0;
    r.created_id    = created;
    r.switched      = sw;
    r.ready_count   = COUNT_W'(ring_count);
    r.tick_count    = now_ticks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done strobe pairs with the oldest pending item.
  // Sample at the rising edge, so the values seen are those of the cycle that
  // edge ends.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("done strobe with no item pending");
        mismatch_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (result.running_valid !== oldest.running_valid) begin
          $error("running_valid: expected %0d, actual %0d",
                 oldest.running_valid, result.running_valid);
          mismatch_count++;
        end
        if (result.running_slot !== oldest.running_slot) begin
          $error("running_slot: expected %0d, actual %0d",
                 oldest.running_slot, result.running_slot);
          mismatch_count++;
        end
        if (result.running_id !== oldest.running_id) begin
          $error("running_id: expected %h, actual %h",
                 oldest.running_id, result.running_id);
          mismatch_count++;
        end
        if (result.created_id !== oldest.created_id) begin
          $error("created_id: expected %h, actual %h",
                 oldest.created_id, result.created_id);
          mismatch_count++;
        end
        if (result.switched !== oldest.switched) begin
          $error("switched: expected %0d, actual %0d",
                 oldest.switched, result.switched);
          mismatch_count++;
        end
        if (result.ready_count !== oldest.ready_count) begin
          $error("ready_count: expected %0d, actual %0d",
                 oldest.ready_count, result.ready_count);
          mismatch_count++;
        end
        if (result.tick_count !== oldest.tick_count) begin
          $error("tick_count: expected %h, actual %h",
                 oldest.tick_count, result.tick_count);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t mk_item(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] t);
    item_t it;
    it.func        = f;
    it.sleep_ticks = t;
    return it;
  endfunction

  // Mostly back to back or a short gap, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sleep lengths: mostly short so tasks come back, plus zero, full-range
  // values and values that wrap the wake time past 2^32.
  function automatic logic [TIME_W-1:0] pick_sleep();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return TIME_W'($urandom_range(0, 15));
    if (r == 6) return '0;
    if (r == 7) return TIME_W'($urandom);
    if (r == 8) return 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 5));
    return TIME_W'($urandom_range(16, 200));
  endfunction

  // Profile 0 balances the requests; profile 1 leans on create to fill the
  // table and run into the full-table case.
  function automatic item_t random_item(input int profile);
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    it.sleep_ticks = TIME_W'($urandom);
    if (profile == 1) begin
      if (r < 25)      it.func = FUNC_TICK;
      else if (r < 65) it.func = FUNC_CREATE;
      else if (r < 75) it.func = FUNC_YIELD;
      else if (r < 85) it.func = FUNC_SLEEP;
      else if (r < 95) it.func = FUNC_EXIT;
      else             it.func = FUNC_W'($urandom_range(5, 7));
    end else begin
      if (r < 40)      it.func = FUNC_TICK;
      else if (r < 55) it.func = FUNC_CREATE;
      else if (r < 68) it.func = FUNC_YIELD;
      else if (r < 80) it.func = FUNC_SLEEP;
      else if (r < 93) it.func = FUNC_EXIT;
      else             it.func = FUNC_W'($urandom_range(5, 7));
    end
    if (it.func == FUNC_SLEEP) it.sleep_ticks = pick_sleep();
    return it;
  endfunction

  // Present one item and hold it until the block takes it. Leave start high
  // on a zero gap, so the next call simply swaps the item in.
  task automatic send_item(input item_t it);
    int gap;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    expected_results.push_back(sched_step(it));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every pending result is in, then let the
  // longest request latency pass so the block is surely idle.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; only call while idle.
  task automatic write_config(input logic [TS_W-1:0] slice, input logic [TIME_W-1:0] warm);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SLICE_LEN;
    cfg_data  <= CFG_DATA_W'(slice);
    @(posedge clk);
    cfg_slice = slice;
    cfg_index <= REG_WARMUP;
    cfg_data  <= warm;
    @(posedge clk);
    cfg_warmup = warm;
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: yield schedules nothing, sleep and exit do nothing, unknown
  // requests only report state, a tick only counts.
  task automatic test_no_task();
    send_item(mk_item(FUNC_YIELD, '0));
    send_item(mk_item(FUNC_SLEEP, 32'hFFFF_FFFF));
    send_item(mk_item(FUNC_EXIT, 32'hFFFF_FFFF));
    send_item(mk_item(3'd5, 32'h5555_5555));
    send_item(mk_item(3'd6, 32'hAAAA_AAAA));
    send_item(mk_item(3'd7, '0));
    send_item(mk_item(FUNC_TICK, '0));
  endtask

  // Fill every slot, then one more create against the full table.
  task automatic test_fill_table();
    repeat (NUM_SLOTS + 1) send_item(mk_item(FUNC_CREATE, '0));
  endtask

  // Run a task, put it to sleep with a wake time that wraps to the past, wake
  // it on the next tick, then sleep for zero ticks and end the current task.
  task automatic test_sleep_and_wake();
    send_item(mk_item(FUNC_YIELD, '0));
    send_item(mk_item(FUNC_SLEEP, 32'hFFFF_FFFF));
    send_item(mk_item(FUNC_TICK, '0));
    send_item(mk_item(FUNC_SLEEP, '0));
    send_item(mk_item(FUNC_TICK, '0));
    send_item(mk_item(FUNC_EXIT, '0));
  endtask

  // Random requests under the current settings; now and then pause until
  // everything pending is back.
  task automatic test_random_phase(input int n, input int profile);
    for (int k = 0; k < n; k++) begin
      send_item(random_item(profile));
      if ($urandom_range(0, 99) < 2) wait_drained();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    item           = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    idle_enable    = 1'b1;
    sched_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings (slice 10, warm-up 100).
    test_no_task();
    test_fill_table();
    test_sleep_and_wake();
    wait_drained();

    // Shortest slice, preemption from the first tick.
    write_config(TS_W'(1), '0);
    test_random_phase(150, 0);

    // Short slice, warm-up crossed mid-phase, no random gaps between items.
    idle_enable = 1'b0;
    write_config(TS_W'(3), now_ticks + TIME_W'(20));
    test_random_phase(150, 0);
    idle_enable = 1'b1;

    // Longest slice, warm-up never exceeded: no preemption; fill the table.
    write_config(16'hFFFF, 32'hFFFF_FFFF);
    test_random_phase(60, 1);

    // Zero slice: a reload leaves 0, so the next counted tick wraps.
    write_config('0, '0);
    test_random_phase(60, 0);

    // A handful of random small settings, warm-up near the current count or small.
    for (int p = 0; p < 4; p++) begin
      write_config(TS_W'($urandom_range(1, 6)),
                   $urandom_range(0, 1) ? now_ticks + TIME_W'($urandom_range(0, 8))
                                        : TIME_W'($urandom_range(0, 30)));
      test_random_phase(60, p % 2);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every item at the longest
  // tick latency plus the longest sender gap).
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
